>>> hdl/sha2c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha2c_pkg
// Round functions, round constants and initial values for the SHA-256 and
// SHA-224 compression engine.
// ----------------------------------------------------------------------------
package sha2c_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned WordsPerBlock = 16;
  localparam int unsigned Rounds        = 64;
  localparam int unsigned ChainWords    = 8;

  localparam logic MODE_SHA256 = 1'b0;
  localparam logic MODE_SHA224 = 1'b1;

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t init_value(input logic mode, input logic [2:0] idx);
    word_t v;
    if (mode == MODE_SHA224) begin
      unique case (idx)
        3'd0: v = 32'hc1059ed8;  3'd1: v = 32'h367cd507;
        3'd2: v = 32'h3070dd17;  3'd3: v = 32'hf70e5939;
        3'd4: v = 32'hffc00b31;  3'd5: v = 32'h68581511;
        3'd6: v = 32'h64f98fa7;  3'd7: v = 32'hbefa4fa4;
        default: v = 32'h0;
      endcase
    end else begin
      unique case (idx)
        3'd0: v = 32'h6a09e667;  3'd1: v = 32'hbb67ae85;
        3'd2: v = 32'h3c6ef372;  3'd3: v = 32'ha54ff53a;
        3'd4: v = 32'h510e527f;  3'd5: v = 32'h9b05688c;
        3'd6: v = 32'h1f83d9ab;  3'd7: v = 32'h5be0cd19;
        default: v = 32'h0;
      endcase
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hdl/sha256_sha224_compression.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_sha224_compression
// SHA-256 / SHA-224 compression engine: takes padded message words, runs one
// round per cycle on a shared round unit and streams out the digest words.
// ----------------------------------------------------------------------------
//  channel | direction | tdata            | tuser (low bit up)           | tlast
//  --------+-----------+------------------+------------------------------+------
//  in_     | slave     | message_word[31:0]| start_message, final_block  | -
//  out_    | master    | digest_word[31:0]| word_number[2:0]             | last
//  cfg_    | write     | mode (cfg_wdata) | -                            | -
//
//  the sixteenth word of a block starts the 64 rounds on the round unit,
//  followed by the chaining add; in_tready is low meanwhile.
//  on a final block the digest follows, one word per accepted out request.
//  rst_n (synchronous) loads the SHA-256 initial values and clears control.
//  a stall on out_tready holds the current digest word and blocks input.
// ----------------------------------------------------------------------------
module sha256_sha224_compression
  import sha2c_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,   // mode
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // message_word
  input  wire logic [1:0]  in_tuser,    // [0] start_message, [1] final_block
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // digest_word
  output logic [2:0]       out_tuser,   // word_number
  output logic             out_tlast    // last
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_ADD   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       mode_r;
  logic [3:0] word_cnt_r;
  logic [5:0] round_r;
  logic [2:0] out_idx_r;
  logic       final_r;

  word_t chain_r [ChainWords];
  word_t wv_r    [ChainWords];
  word_t sched_r [WordsPerBlock];

  logic  in_acc, out_acc, blk_done, start_w, out_last;
  word_t t1, t2, w_new;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign start_w  = in_tuser[0];
  // a start word always becomes word 0, so it never completes a block
  assign blk_done = in_acc && (word_cnt_r == 4'd15) && !start_w;

  // shared round unit
  assign t1 = wv_r[7] + big_sigma1(wv_r[4]) + choose(wv_r[4], wv_r[5], wv_r[6])
              + round_k(round_r) + sched_r[0];
  assign t2 = big_sigma0(wv_r[0]) + majority(wv_r[0], wv_r[1], wv_r[2]);
  // rolling schedule: next word sixteen rounds ahead
  assign w_new = small_sigma1(sched_r[14]) + sched_r[9]
                 + small_sigma0(sched_r[1]) + sched_r[0];

  assign out_last = (mode_r == MODE_SHA224) ? (out_idx_r == 3'd6) : (out_idx_r == 3'd7);

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = chain_r[out_idx_r];
  assign out_tuser  = out_idx_r;
  assign out_tlast  = out_last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:  if (blk_done) state_nxt = S_ROUND;
      S_ROUND: if (round_r == 6'd63) state_nxt = S_ADD;
      S_ADD:   state_nxt = final_r ? S_OUT : S_LOAD;
      S_OUT:   if (out_acc && out_last) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      mode_r     <= MODE_SHA256;
      word_cnt_r <= 4'd0;
      round_r    <= 6'd0;
      out_idx_r  <= 3'd0;
      final_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
      if (in_acc) begin
        word_cnt_r <= start_w ? 4'd1 : word_cnt_r + 4'd1;
        if (blk_done) final_r <= in_tuser[1];
      end
      if (state_r == S_ROUND) round_r <= round_r + 6'd1;
      if (out_acc) out_idx_r <= out_last ? 3'd0 : out_idx_r + 3'd1;
    end
  end

  // chaining value: reset to the SHA-256 initial values, loaded with the mode's initial values on a start word
  always_ff @(posedge clk) begin
    for (int i = 0; i < ChainWords; i++) begin
      if (!rst_n) begin
        chain_r[i] <= init_value(MODE_SHA256, 3'(i));
      end else if (in_acc && start_w) begin
        chain_r[i] <= init_value(mode_r, 3'(i));
      end else if (state_r == S_ADD) begin
        chain_r[i] <= chain_r[i] + wv_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ChainWords; i++) wv_r[i] <= '0;
    end else if (blk_done) begin
      for (int i = 0; i < ChainWords; i++) wv_r[i] <= chain_r[i];
    end else if (state_r == S_ROUND) begin
      wv_r[0] <= t1 + t2;
      wv_r[1] <= wv_r[0];
      wv_r[2] <= wv_r[1];
      wv_r[3] <= wv_r[2];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[5] <= wv_r[4];
      wv_r[6] <= wv_r[5];
      wv_r[7] <= wv_r[6];
    end
  end

  // schedule shifts in from the top, both while loading and in rounds
  always_ff @(posedge clk) begin
    if (in_acc || state_r == S_ROUND) begin
      for (int i = 0; i < WordsPerBlock - 1; i++) sched_r[i] <= sched_r[i + 1];
      sched_r[WordsPerBlock - 1] <= in_acc ? in_tdata : w_new;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open at once");

  a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !start_w && word_cnt_r == 4'd15) |=> (state_r == S_ROUND && round_r == 6'd0))
    else $error("sixteenth word did not start the rounds");

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && round_r == 6'd63) |=> (state_r == S_ADD && round_r == 6'd0))
    else $error("round count out of step");

  a_digest_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (in_tready && out_tuser == 3'd0))
    else $error("digest did not close cleanly");

endmodule
`default_nettype wire

>>> tb/sha256_sha224_compression_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_sha224_compression_test
// Streams padded message words into the SHA-256 / SHA-224 compression engine
// and checks every digest word against a behavioral hash model kept here.
// Covers both modes, restarts inside a block, ignored final flags, chaining
// without a start, mode changes inside a message and output back-pressure.
// ----------------------------------------------------------------------------
module sha256_sha224_compression_test
  import sha2c_pkg::*;
();

  localparam int unsigned BlockLatency = 100;    // covers the rounds and the chaining add, plus margin
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned CycleLimit   = 200000;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t IV_SHA256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t IV_SHA224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  typedef struct {
    word_t      value;
    logic [2:0] index;
    logic       last;
  } digest_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;    // message_word
  logic [1:0]  in_tuser   = '0;    // [0] start_message, [1] final_block
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // digest_word
  logic [2:0]  out_tuser;          // word_number
  logic        out_tlast;

  // hash model state
  logic        model_mode;
  word_t       chain [8];
  word_t       sched [16];
  int unsigned word_pos;
  digest_word_t digest_q [$];

  bit          idle_en = 1'b1;
  int unsigned holds_asked;
  int unsigned holds_served;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned words_sent;
  int unsigned digest_words;
  int unsigned digests_done;
  int unsigned failures;
  int unsigned cycle_count;

  sha256_sha224_compression dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    word_t w [64];
    word_t v [8];
    word_t s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = sched[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  // advance the hash model by one accepted word and queue any digest
  function automatic void hash_word(input word_t word, input logic start, input logic fin);
    int unsigned n;
    digest_word_t d;
    if (start) begin
      for (int i = 0; i < 8; i++)
        chain[i] = (model_mode == MODE_SHA224) ? IV_SHA224[i] : IV_SHA256[i];
      word_pos = 0;
    end
    sched[word_pos] = word;
    if (word_pos < 15) begin
      word_pos++;
      return;
    end
    word_pos = 0;
    compress_block();
    if (!fin) return;
    n = (model_mode == MODE_SHA224) ? 7 : 8;
    for (int i = 0; i < n; i++) begin
      d.value = chain[i];
      d.index = i[2:0];
      d.last  = (i == n - 1);
      digest_q.push_back(d);
    end
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // called just after a falling edge, returns just after one with in_tvalid high
  task automatic send_word(input word_t word, input logic start, input logic fin);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= {fin, start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hash_word(word, start, fin);
    words_sent++;
    @(negedge clk);
  endtask

  // final flag is random on every word but the sixteenth of each block
  task automatic send_message(input int unsigned blocks, input bit with_start,
                              input int unsigned stop_after);
    int unsigned total;
    logic fin;
    total = blocks * 16;
    for (int unsigned k = 0; k < total && k < stop_after; k++) begin
      fin = (k % 16 == 15) ? (k == total - 1) : 1'($urandom_range(0, 1));
      send_word(rand_word(), with_start && (k == 0), fin);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
    repeat (BlockLatency) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    model_mode = m;
  endtask

  task automatic random_traffic(input int unsigned target);
    int unsigned pick;
    while (words_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_message($urandom_range(1, 2), 1'b1, 32);
      end else if (pick < 7) begin
        // no start: keeps chaining from the current value
        send_message(1, 1'b0, 16);
      end else if (pick < 9) begin
        // abandoned message, the next start drops it
        send_message(2, 1'b1, $urandom_range(1, 31));
      end else begin
        drain();
        write_mode(1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_directed();
    write_mode(MODE_SHA256);
    // no start after reset, extreme words, a final flag early in the block
    for (int k = 0; k < 16; k++)
      send_word((k % 2) ? 32'hffff_ffff : 32'h0000_0000, 1'b0, (k == 3) || (k == 15));
    // a start inside a block drops the words before it
    for (int k = 0; k < 6; k++)
      send_word(rand_word(), (k == 0) || (k == 4), 1'b0);
    drain();
  endtask

  task automatic test_mode_change_mid_message();
    send_message(1, 1'b1, 8);
    drain();
    write_mode(MODE_SHA224);
    for (int k = 0; k < 8; k++) send_word(rand_word(), 1'b0, k == 7);
    drain();
    send_message(1, 1'b1, 8);
    drain();
    write_mode(MODE_SHA256);
    for (int k = 0; k < 8; k++) send_word(rand_word(), 1'b0, k == 7);
    drain();
  endtask

  task automatic test_sha224_messages();
    write_mode(MODE_SHA224);
    send_message(1, 1'b1, 16);
    send_message(2, 1'b1, 32);
    drain();
  endtask

  task automatic test_random_mix();
    random_traffic(110);
    drain();
  endtask

  task automatic test_output_stall();
    write_mode(MODE_SHA256);
    holds_asked++;
    // digest backs up, then the next message has to wait at the input
    send_message(1, 1'b1, 16);
    send_message(2, 1'b1, 32);
    drain();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    random_traffic(205);
    drain();
  endtask

  // receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    digest_word_t d;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, got %h (word %0d, last %b)",
                 $time, out_tdata, out_tuser, out_tlast);
        failures++;
      end else begin
        d = digest_q.pop_front();
        digest_words++;
        if (d.last) digests_done++;
        if (out_tdata !== d.value) begin
          $display("%0t: digest_word expected %h got %h", $time, d.value, out_tdata);
          failures++;
        end
        if (out_tuser !== d.index) begin
          $display("%0t: word_number expected %0d got %0d", $time, d.index, out_tuser);
          failures++;
        end
        if (out_tlast !== d.last) begin
          $display("%0t: last expected %b got %b", $time, d.last, out_tlast);
          failures++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d digest words outstanding", $time, digest_q.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    model_mode = MODE_SHA256;
    for (int i = 0; i < 8; i++) chain[i] = IV_SHA256[i];
    word_pos = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_mode_change_mid_message();
    test_sha224_messages();
    test_random_mix();
    test_output_stall();
    test_back_to_back();

    if (digest_q.size() != 0) begin
      $display("%0t: %0d digest words never arrived, next expected %h",
               $time, digest_q.size(), digest_q[0].value);
      failures++;
    end
    $display("Run covered %0d message words in SHA-256 and SHA-224 modes", words_sent);
    $display("%0d digests (%0d words) compared, %0d errors", digests_done, digest_words,
             failures);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
